[rtl/core/ssc_pkg.sv]
// Sheet size constrainer: shared types, constants and rounding helpers.
// No dependencies.
package ssc_pkg;

  // Internal signed working width; covers every intermediate size.
  localparam int SSC_IW = 24;
  // Default width of the result ports.
  localparam int SSC_SIZE_BITS = 22;
  // Remainder pipeline resolves two dividend bits per stage.
  localparam int SSC_MOD_STAGES = SSC_IW / 2;
  // Start to done: 5 single stages plus two remainder pipes.
  localparam int SSC_LATENCY = 5 + 2 * (SSC_MOD_STAGES + 1);

  localparam int SSC_ALIGN_BITS = 16;

  typedef logic signed [SSC_IW-1:0] size_t;

  typedef enum logic [2:0] {
    REG_MIN_W   = 3'd0,
    REG_MIN_H   = 3'd1,
    REG_MAX_W   = 3'd2,
    REG_MAX_H   = 3'd3,
    REG_PAD     = 3'd4,
    REG_EXTRA   = 3'd5,
    REG_ALIGN   = 3'd6,
    REG_SHAPE   = 3'd7
  } reg_idx_e;

  localparam logic [19:0] SSC_MAX_RESET = 20'd1000000;

  // OR every bit into all bits below it.
  function automatic logic [SSC_IW-1:0] smear(input logic [SSC_IW-1:0] v);
    logic [SSC_IW-1:0] s;
    s = v;
    s = s | (s >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    return s;
  endfunction

  // Smallest power of two not below x; one for x below two.
  function automatic size_t pot_up(input size_t x);
    logic [SSC_IW-1:0] y;
    y = SSC_IW'(x - size_t'(1));
    if (x <= size_t'(1)) begin
      return size_t'(1);
    end
    return size_t'(smear(y) + SSC_IW'(1));
  endfunction

  // Largest power of two not above x; one for x below one.
  function automatic size_t pot_down(input size_t x);
    logic [SSC_IW-1:0] s;
    s = smear(SSC_IW'(x));
    if (x < size_t'(1)) begin
      return size_t'(1);
    end
    return size_t'(s ^ (s >> 1));
  endfunction

endpackage

[rtl/core/ssc_modpipe.sv]
// Pipelined rounding of a signed size to a multiple of a 16-bit alignment.
// Uses ssc_pkg; two remainder bits per stage, then a rounding stage.
module ssc_modpipe (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              round_up_i,
  input  logic [ssc_pkg::SSC_ALIGN_BITS-1:0] align_i,
  input  logic                              valid_i,
  input  ssc_pkg::size_t                    x_i,
  input  ssc_pkg::size_t                    aux_i,
  output logic                              valid_o,
  output ssc_pkg::size_t                    x_o,
  output ssc_pkg::size_t                    aux_o
);
  import ssc_pkg::*;

  localparam int AB = SSC_ALIGN_BITS;
  localparam int NS = SSC_MOD_STAGES;

  logic               v_q   [NS];
  logic [AB-1:0]      rem_q [NS];
  logic [SSC_IW-1:0]  mag_q [NS];
  size_t              x_q   [NS];
  size_t              aux_q [NS];

  logic [AB:0] m_ext;
  assign m_ext = {1'b0, align_i};

  // Remainder stages
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic              v_in;
    logic [AB-1:0]     rem_in;
    logic [SSC_IW-1:0] mag_in;
    size_t             x_in;
    size_t             aux_in;
    logic [AB:0]       t1, t2;
    logic [AB-1:0]     r1, r2;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = '0;
      assign mag_in = x_i[SSC_IW-1] ? SSC_IW'(-x_i) : SSC_IW'(x_i);
      assign x_in   = x_i;
      assign aux_in = aux_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign rem_in = rem_q[s-1];
      assign mag_in = mag_q[s-1];
      assign x_in   = x_q[s-1];
      assign aux_in = aux_q[s-1];
    end

    always_comb begin
      t1 = {rem_in, mag_in[SSC_IW-1-2*s]};
      r1 = (t1 >= m_ext) ? AB'(t1 - m_ext) : AB'(t1);
      t2 = {r1, mag_in[SSC_IW-2-2*s]};
      r2 = (t2 >= m_ext) ? AB'(t2 - m_ext) : AB'(t2);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= r2;
      mag_q[s] <= mag_in;
      x_q[s]   <= x_in;
      aux_q[s] <= aux_in;
    end
  end

  // Rounding stage: positive remainder, then ceiling or floor
  size_t rem_s, m_s, res_d, x_last;
  logic  neg_last;
  always_comb begin
    x_last   = x_q[NS-1];
    neg_last = x_last[SSC_IW-1];
    m_s      = size_t'(align_i);
    rem_s    = size_t'(rem_q[NS-1]);
    if (neg_last && rem_s != '0) begin
      rem_s = m_s - rem_s;
    end
    if (align_i == '0) begin
      res_d = x_last;
    end else if (round_up_i) begin
      res_d = (rem_s != '0) ? x_last - rem_s + m_s : x_last;
    end else begin
      res_d = x_last - rem_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    x_o   <= res_d;
    aux_o <= aux_q[NS-1];
  end

endmodule

[rtl/core/sheet_size_constrainer_unit.sv]
// Sheet size constrainer, top level: config registers and pipeline stages.
// Uses ssc_pkg and ssc_modpipe.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  request   | start, busy           | req_width_i, req_height_i
//  result    | done_o (one cycle)    | fixed_width_o, fixed_height_o
//  config    | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//
// One request per cycle while busy is low; each result follows its start through
// the pipeline stages and the two 12-stage alignment remainder pipes.
// busy is high during reset and in the cycle after reset is released; after that the
// pipeline takes a request every cycle and never stalls.
// Reset restores the register defaults and empties the pipeline.
module sheet_size_constrainer_unit #(
  parameter int SIZE_BITS = ssc_pkg::SSC_SIZE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [19:0]          req_width_i,
  input  logic [19:0]          req_height_i,
  output logic                 done_o,
  output logic [SIZE_BITS-1:0] fixed_width_o,
  output logic [SIZE_BITS-1:0] fixed_height_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  ssc_pkg::reg_idx_e    cfg_index_i,
  input  logic [19:0]          cfg_data_i
);
  import ssc_pkg::*;

  // Configuration registers
  logic [19:0] min_w_q, min_h_q, max_w_q, max_h_q;
  logic [15:0] pad_q, extra_q, align_q;
  logic [1:0]  shape_q;
  logic        init_q;

  assign busy        = ~init_q;
  assign cfg_ready_o = init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= 1'b0;
      min_w_q <= '0;
      min_h_q <= '0;
      max_w_q <= SSC_MAX_RESET;
      max_h_q <= SSC_MAX_RESET;
      pad_q   <= '0;
      extra_q <= '0;
      align_q <= '0;
      shape_q <= '0;
    end else begin
      init_q <= 1'b1;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MIN_W: min_w_q <= cfg_data_i;
          REG_MIN_H: min_h_q <= cfg_data_i;
          REG_MAX_W: max_w_q <= cfg_data_i;
          REG_MAX_H: max_h_q <= cfg_data_i;
          REG_PAD:   pad_q   <= cfg_data_i[15:0];
          REG_EXTRA: extra_q <= cfg_data_i[15:0];
          REG_ALIGN: align_q <= cfg_data_i[15:0];
          REG_SHAPE: shape_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
    end
  end

  // Derived constants; the user must keep them stable while requests are in flight, the block does not enforce it
  size_t delta, lim_w, lim_h;
  logic  pot, square;
  assign delta  = size_t'({1'b0, pad_q, 1'b0}) - size_t'(extra_q);
  assign lim_w  = size_t'(max_w_q) + delta;
  assign lim_h  = size_t'(max_h_q) + delta;
  assign pot    = shape_q[0];
  assign square = shape_q[1];

  logic accept;
  assign accept = start & ~busy;

  // Stage 1: minimum, then outer size
  logic        v1_q;
  size_t       w1_q, h1_q;
  logic [19:0] w0, h0;
  assign w0 = (req_width_i  < min_w_q) ? min_w_q : req_width_i;
  assign h0 = (req_height_i < min_h_q) ? min_h_q : req_height_i;

  // Stage 2: power of two upwards when pot is set
  logic  v2_q;
  size_t w2_q, h2_q;

  // Stage 3: square by larger side, clamp to maximum
  logic  v3_q;
  size_t w3_q, h3_q;
  logic  vu;
  size_t wu, hu, ws, hs;

  // Stage 4: power of two downwards when pot is set
  logic  v4_q;
  size_t w4_q, h4_q;

  // Stage 5: square by smaller side, back to inner size
  logic  vd;
  size_t wd, hd, wf, hf;
  logic  v5_q;
  size_t w5_q, h5_q;

  always_comb begin
    ws = wu;
    hs = hu;
    if (square) begin
      if (hu > wu) ws = hu;
      else         hs = wu;
    end
    if (ws > lim_w) ws = lim_w;
    if (hs > lim_h) hs = lim_h;

    wf = wd;
    hf = hd;
    if (square) begin
      if (hd < wd) wf = hd;
      else         hf = wd;
    end
    wf = wf - delta;
    hf = hf - delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= vu;
      v4_q <= v3_q;
      v5_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q <= size_t'(w0) + delta;
    h1_q <= size_t'(h0) + delta;
    w2_q <= pot ? pot_up(w1_q) : w1_q;
    h2_q <= pot ? pot_up(h1_q) : h1_q;
    w3_q <= ws;
    h3_q <= hs;
    w4_q <= pot ? pot_down(w3_q) : w3_q;
    h4_q <= pot ? pot_down(h3_q) : h3_q;
    w5_q <= wf;
    h5_q <= hf;
  end

  // Width alignment, ceiling
  ssc_modpipe u_align_up (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .round_up_i (1'b1),
    .align_i    (align_q),
    .valid_i    (v2_q),
    .x_i        (w2_q),
    .aux_i      (h2_q),
    .valid_o    (vu),
    .x_o        (wu),
    .aux_o      (hu)
  );

  // Width alignment, floor
  ssc_modpipe u_align_dn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .round_up_i (1'b0),
    .align_i    (align_q),
    .valid_i    (v4_q),
    .x_i        (w4_q),
    .aux_i      (h4_q),
    .valid_o    (vd),
    .x_o        (wd),
    .aux_o      (hd)
  );

  assign done_o         = v5_q;
  assign fixed_width_o  = SIZE_BITS'(w5_q);
  assign fixed_height_o = SIZE_BITS'(h5_q);

  // Every accepted request gives exactly one result after the fixed latency
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && !busy, SSC_LATENCY))
    else $error("result strobe does not match request latency");

  // No result leaves while the block is still coming out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !done_o && !vd && !vu)
    else $error("pipeline not empty after reset");

endmodule
